/* rtl/kgww_pkg.sv */
// ----------------------------------------------------------------------------
// kgww_pkg: shared definitions for the kerned greedy word wrap core
// Types, character codes, register indexes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kgww_pkg;

  // Line and word widths never pass wrap_width + glyph_spacing + two glyphs.
  localparam int unsigned LW_W = 18;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_SP = 8'd32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_SELECT   = 2'd2;

  // What the closing step of a text item does.
  typedef enum logic [2:0] {
    ACT_NEWLINE,    // emit a newline and start a new line
    ACT_HOLD_SP,    // the space becomes the new break candidate
    ACT_APPEND,     // the character joins the held word
    ACT_EMIT_C,     // the character goes out as it is
    ACT_REMEASURE   // the held space broke; measure the character again
  } kgww_act_t;

  typedef struct packed {
    logic in_ready;
    logic decide;      // latch the decision for the accepted character
    logic hold_rd;     // read the hold buffer at the index
    logic tbl_rd_rm;   // look up the width of the held byte just read
    logic rel_emit;    // send the held byte out unchanged
    logic rel_done;    // the held run is empty again
    logic rm_nl;       // the held space goes out as a newline
    logic rm_emit;     // send out the re-measured held byte
    logic final_step;  // closing step of the item
  } kgww_cmd_t;

  typedef struct packed {
    logic      in_valid;
    logic      in_mode;
    logic      out_free;
    logic      rel_now;
    kgww_act_t act_now;
    logic      final_emits;
    logic      idx_last;
    logic      hold_many;
  } kgww_status_t;

endpackage

`default_nettype wire

/* rtl/kgww_if.sv */
// ----------------------------------------------------------------------------
// kgww_if: valid/ready channels of the word wrap core
// The input channel carries text bytes and width table loads, the output
// channel carries the rewritten text.
// ----------------------------------------------------------------------------
`default_nettype none

interface kgww_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;
  logic [7:0] glyph_width;
  logic [2:0] load_font;
  logic       end_of_text;

  modport source (
    output valid, mode, char_code, glyph_width, load_font, end_of_text,
    input  ready
  );
  modport sink (
    input  valid, mode, char_code, glyph_width, load_font, end_of_text,
    output ready
  );
endinterface

interface kgww_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;

  modport source (
    output valid, char_out, last_out,
    input  ready
  );
  modport sink (
    input  valid, char_out, last_out,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/kgww_ram.sv */
// ----------------------------------------------------------------------------
// kgww_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kgww_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/kgww_ctrl.sv */
// ----------------------------------------------------------------------------
// kgww_ctrl: sequencer of the word wrap core
// Steps each text item through its decision, the release or re-measure of
// the held word, and its closing step.
// ----------------------------------------------------------------------------
`default_nettype none

module kgww_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire kgww_pkg::kgww_status_t status,
  output kgww_pkg::kgww_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_REL_RD,
    S_REL_EMIT,
    S_RM_NL,
    S_RM_RD,
    S_RM_TBL,
    S_RM_EMIT,
    S_FINAL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   fin_fire;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    fin_fire  = !status.final_emits || status.out_free;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid && status.in_mode) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.rel_now) begin
          state_nxt = S_REL_RD;
        end else if (status.act_now == kgww_pkg::ACT_REMEASURE) begin
          state_nxt = S_RM_NL;
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_REL_RD: begin
        cmd.hold_rd = 1'b1;
        state_nxt   = S_REL_EMIT;
      end
      S_REL_EMIT: begin
        if (status.out_free) begin
          cmd.rel_emit = 1'b1;
          if (status.idx_last) begin
            cmd.rel_done = 1'b1;
            state_nxt    = S_FINAL;
          end else begin
            state_nxt = S_REL_RD;
          end
        end
      end
      S_RM_NL: begin
        if (status.out_free) begin
          cmd.rm_nl = 1'b1;
          state_nxt = status.hold_many ? S_RM_RD : S_FINAL;
        end
      end
      S_RM_RD: begin
        cmd.hold_rd = 1'b1;
        state_nxt   = S_RM_TBL;
      end
      S_RM_TBL: begin
        cmd.tbl_rd_rm = 1'b1;
        state_nxt     = S_RM_EMIT;
      end
      S_RM_EMIT: begin
        if (status.out_free) begin
          cmd.rm_emit = 1'b1;
          state_nxt   = status.idx_last ? S_FINAL : S_RM_RD;
        end
      end
      S_FINAL: begin
        // The next item may enter in the same cycle as the closing step.
        if (fin_fire) begin
          cmd.final_step = 1'b1;
          cmd.in_ready   = 1'b1;
          state_nxt      = (status.in_valid && status.in_mode) ? S_DECIDE : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/kgww_datapath.sv */
// ----------------------------------------------------------------------------
// kgww_datapath: storage and arithmetic of the word wrap core
// Width tables, hold buffer, line state, configuration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kgww_datapath #(
  parameter int unsigned FONT_COUNT = 5,
  parameter int unsigned HOLD_DEPTH = 63
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  kgww_in_if.sink                                  in_ch,
  kgww_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [kgww_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [kgww_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire kgww_pkg::kgww_cmd_t                 cmd,
  output kgww_pkg::kgww_status_t                   status
);

  localparam int unsigned TBL_DEPTH = FONT_COUNT * 256;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned HB_AW     = $clog2(HOLD_DEPTH);
  localparam int unsigned HC_W      = $clog2(HOLD_DEPTH + 1);
  localparam int unsigned FONT_LAST = FONT_COUNT - 1;
  localparam int unsigned LW_W      = kgww_pkg::LW_W;

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [2:0] f, input logic [7:0] c);
    return TBL_AW'({f, c});
  endfunction

  // Configuration registers
  logic [15:0] wrap_r,    wrap_nxt;
  logic [7:0]  spacing_r, spacing_nxt;
  logic [2:0]  font_r,    font_nxt;

  // Line state
  logic [LW_W-1:0] line_width_r,    line_width_nxt;
  logic            at_line_start_r, at_line_start_nxt;
  logic [HC_W-1:0] hold_count_r,    hold_count_nxt;
  logic [HB_AW-1:0] idx_r,          idx_nxt;

  // Item and decision registers
  logic [7:0]          c_r,      c_nxt;
  logic                e_r,      e_nxt;
  logic [7:0]          w_c_r,    w_c_nxt;
  logic [LW_W-1:0]     lw_new_r, lw_new_nxt;
  kgww_pkg::kgww_act_t act_r,    act_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r,  out_char_nxt;
  logic       out_last_r,  out_last_nxt;

  logic              accept;
  logic [2:0]        font_sel;
  logic              load_ok;
  logic              tbl_we;
  logic              tbl_re;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [7:0]        tbl_rdata;
  logic              hold_we;
  logic [HB_AW-1:0]  hold_waddr;
  logic [7:0]        hold_rdata;

  logic [LW_W-1:0] live_base, live_sum, fin_base, fin_sum;
  logic            live_over, fin_over;
  logic            held, brk_sp, out_free;
  kgww_pkg::kgww_act_t act_now;
  logic            rel_now;
  logic            final_emits;
  logic [7:0]      final_byte;

  assign accept   = in_ch.valid && cmd.in_ready;
  assign font_sel = ({1'b0, font_r} < 4'(FONT_COUNT)) ? font_r : 3'(FONT_LAST);
  assign load_ok  = {1'b0, in_ch.load_font} < 4'(FONT_COUNT);

  assign tbl_we    = accept && !in_ch.mode && load_ok;
  assign tbl_waddr = tbl_addr(in_ch.load_font, in_ch.char_code);
  assign tbl_re    = (accept && in_ch.mode) || cmd.tbl_rd_rm;
  assign tbl_raddr = cmd.tbl_rd_rm ? tbl_addr(font_sel, hold_rdata)
                                   : tbl_addr(font_sel, in_ch.char_code);

  kgww_ram #(
    .WIDTH (8),
    .DEPTH (TBL_DEPTH)
  ) u_width_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_ch.glyph_width),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign hold_we = cmd.final_step &&
                   ((act_r == kgww_pkg::ACT_APPEND) ||
                    (act_r == kgww_pkg::ACT_HOLD_SP && !e_r));
  assign hold_waddr = (act_r == kgww_pkg::ACT_APPEND) ? hold_count_r[HB_AW-1:0] : '0;

  kgww_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_buffer (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (c_r),
    .re    (cmd.hold_rd),
    .raddr (idx_r),
    .rdata (hold_rdata)
  );

  // A glyph overflows when line + width exceeds wrap_width; the spacing
  // cancels on both sides of the comparison.
  assign live_base = line_width_r + LW_W'(tbl_rdata);
  assign live_sum  = live_base + LW_W'(spacing_r);
  assign live_over = live_base > LW_W'(wrap_r);
  assign fin_base  = line_width_r + LW_W'(w_c_r);
  assign fin_sum   = fin_base + LW_W'(spacing_r);
  assign fin_over  = fin_base > LW_W'(wrap_r);

  assign held     = hold_count_r != '0;
  assign brk_sp   = (c_r == kgww_pkg::CHAR_SP) && !at_line_start_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    act_now = kgww_pkg::ACT_NEWLINE;
    rel_now = held;
    priority if (c_r == kgww_pkg::CHAR_NL) begin
      act_now = kgww_pkg::ACT_NEWLINE;
    end else if (!live_over && brk_sp) begin
      act_now = kgww_pkg::ACT_HOLD_SP;
    end else if (!live_over && held) begin
      if (e_r || hold_count_r == HC_W'(HOLD_DEPTH - 1)) begin
        act_now = kgww_pkg::ACT_EMIT_C;
      end else begin
        act_now = kgww_pkg::ACT_APPEND;
        rel_now = 1'b0;
      end
    end else if (!live_over) begin
      act_now = kgww_pkg::ACT_EMIT_C;
    end else if (brk_sp) begin
      act_now = kgww_pkg::ACT_NEWLINE;
    end else if (held) begin
      act_now = kgww_pkg::ACT_REMEASURE;
      rel_now = 1'b0;
    end else begin
      act_now = kgww_pkg::ACT_NEWLINE;
    end
  end

  always_comb begin
    unique case (act_r)
      kgww_pkg::ACT_NEWLINE: begin
        final_emits = 1'b1;
        final_byte  = kgww_pkg::CHAR_NL;
      end
      kgww_pkg::ACT_HOLD_SP: begin
        final_emits = e_r;
        final_byte  = c_r;
      end
      kgww_pkg::ACT_APPEND: begin
        final_emits = 1'b0;
        final_byte  = c_r;
      end
      kgww_pkg::ACT_EMIT_C: begin
        final_emits = 1'b1;
        final_byte  = c_r;
      end
      kgww_pkg::ACT_REMEASURE: begin
        final_emits = 1'b1;
        final_byte  = fin_over ? kgww_pkg::CHAR_NL : c_r;
      end
      default: begin
        final_emits = 1'b0;
        final_byte  = c_r;
      end
    endcase
  end

  always_comb begin
    wrap_nxt          = wrap_r;
    spacing_nxt       = spacing_r;
    font_nxt          = font_r;
    line_width_nxt    = line_width_r;
    at_line_start_nxt = at_line_start_r;
    hold_count_nxt    = hold_count_r;
    idx_nxt           = idx_r;
    c_nxt             = c_r;
    e_nxt             = e_r;
    w_c_nxt           = w_c_r;
    lw_new_nxt        = lw_new_r;
    act_nxt           = act_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_char_nxt      = out_char_r;
    out_last_nxt      = out_last_r;

    if (cfg_we) begin
      unique case (cfg_index)
        kgww_pkg::CFG_WRAP_WIDTH:    wrap_nxt    = cfg_wdata;
        kgww_pkg::CFG_GLYPH_SPACING: spacing_nxt = cfg_wdata[7:0];
        kgww_pkg::CFG_FONT_SELECT:   font_nxt    = cfg_wdata[2:0];
        default: begin
        end
      endcase
    end

    if (accept && in_ch.mode) begin
      c_nxt = in_ch.char_code;
      e_nxt = in_ch.end_of_text;
    end

    if (cmd.decide) begin
      act_nxt    = act_now;
      w_c_nxt    = tbl_rdata;
      lw_new_nxt = live_sum;
      idx_nxt    = '0;
    end

    if (cmd.rel_emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = hold_rdata;
      out_last_nxt  = 1'b0;
      idx_nxt       = idx_r + 1'b1;
    end
    if (cmd.rel_done) begin
      hold_count_nxt = '0;
    end

    if (cmd.rm_nl) begin
      out_valid_nxt     = 1'b1;
      out_char_nxt      = kgww_pkg::CHAR_NL;
      out_last_nxt      = 1'b0;
      line_width_nxt    = '0;
      at_line_start_nxt = 1'b1;
      idx_nxt           = HB_AW'(1);
    end

    if (cmd.rm_emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b0;
      idx_nxt       = idx_r + 1'b1;
      if (live_over) begin
        // A held byte that no longer fits on the line is replaced by a newline.
        out_char_nxt      = kgww_pkg::CHAR_NL;
        line_width_nxt    = '0;
        at_line_start_nxt = 1'b1;
      end else begin
        out_char_nxt      = hold_rdata;
        line_width_nxt    = live_sum;
        at_line_start_nxt = 1'b0;
      end
    end

    if (cmd.final_step) begin
      if (final_emits) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = final_byte;
        out_last_nxt  = e_r;
      end
      unique case (act_r)
        kgww_pkg::ACT_NEWLINE: begin
          line_width_nxt    = '0;
          at_line_start_nxt = 1'b1;
        end
        kgww_pkg::ACT_HOLD_SP: begin
          line_width_nxt    = lw_new_r;
          at_line_start_nxt = 1'b0;
          hold_count_nxt    = e_r ? '0 : HC_W'(1);
        end
        kgww_pkg::ACT_APPEND: begin
          line_width_nxt    = lw_new_r;
          at_line_start_nxt = 1'b0;
          hold_count_nxt    = hold_count_r + 1'b1;
        end
        kgww_pkg::ACT_EMIT_C: begin
          line_width_nxt    = lw_new_r;
          at_line_start_nxt = 1'b0;
        end
        kgww_pkg::ACT_REMEASURE: begin
          hold_count_nxt = '0;
          if (fin_over) begin
            line_width_nxt    = '0;
            at_line_start_nxt = 1'b1;
          end else begin
            line_width_nxt    = fin_sum;
            at_line_start_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (e_r) begin
        line_width_nxt    = '0;
        at_line_start_nxt = 1'b1;
        hold_count_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r          <= '0;
      spacing_r       <= '0;
      font_r          <= '0;
      line_width_r    <= '0;
      at_line_start_r <= 1'b1;
      hold_count_r    <= '0;
      idx_r           <= '0;
      act_r           <= kgww_pkg::ACT_NEWLINE;
      out_valid_r     <= 1'b0;
    end else begin
      wrap_r          <= wrap_nxt;
      spacing_r       <= spacing_nxt;
      font_r          <= font_nxt;
      line_width_r    <= line_width_nxt;
      at_line_start_r <= at_line_start_nxt;
      hold_count_r    <= hold_count_nxt;
      idx_r           <= idx_nxt;
      act_r           <= act_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    c_r        <= c_nxt;
    e_r        <= e_nxt;
    w_c_r      <= w_c_nxt;
    lw_new_r   <= lw_new_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready     = cmd.in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last_out = out_last_r;

  always_comb begin
    status             = '0;
    status.in_valid    = in_ch.valid;
    status.in_mode     = in_ch.mode;
    status.out_free    = out_free;
    status.rel_now     = rel_now;
    status.act_now     = act_now;
    status.final_emits = final_emits;
    status.idx_last    = (HC_W'(idx_r) + HC_W'(1)) == hold_count_r;
    status.hold_many   = hold_count_r > HC_W'(1);
  end

  // The held run is released before it can fill the buffer.
  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hold_count_r < HC_W'(HOLD_DEPTH))
    else $error("hold buffer count reached its depth");

  // Every hold buffer read falls inside the held run.
  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_rd |-> (HC_W'(idx_r) < hold_count_r))
    else $error("hold buffer read beyond the held run");

  // Re-measuring runs only after a break at the held space.
  a_rm_act: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rm_nl || cmd.rm_emit) |-> (act_r == kgww_pkg::ACT_REMEASURE))
    else $error("re-measure step without a break at the held space");

  // The width table read port is never claimed twice in one cycle.
  a_tbl_port: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_rd_rm |-> !accept)
    else $error("width table read port claimed twice");

  // End of text leaves the line state at its reset values.
  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.final_step && e_r) |=>
      (hold_count_r == '0 && at_line_start_r && line_width_r == '0))
    else $error("line state not cleared after end of text");

endmodule

`default_nettype wire

/* rtl/kerned_greedy_word_wrap_core.sv */
// ----------------------------------------------------------------------------
// kerned_greedy_word_wrap_core: pixel-width greedy word wrap of a byte stream
// Rewrites text so every line fits wrap_width, using loadable glyph widths.
// ----------------------------------------------------------------------------
// Text bytes (mode 1) and width table loads (mode 0) arrive on in_ch; the
// rewritten text leaves on out_ch, with last_out set on the final byte that
// belongs to an item marked end_of_text. A load item writes the width table
// directly. A text item that neither releases nor re-breaks the held word
// has a decide step, which uses the glyph width looked up when the item was
// accepted, and a closing step that already accepts the next item. Each
// released held byte is a registered read of the hold buffer followed by a
// step that loads it into the output register. A break at the held space
// adds a step for the newline, then for each re-measured byte a hold buffer
// read, a width table read, and the add and compare.
// Output back-pressure stalls the sequence at whichever step is emitting.
// The width tables and the hold buffer come up with unknown contents and
// need no clearing pass; configuration registers reset to zero and should
// only be written while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module kerned_greedy_word_wrap_core #(
  parameter int unsigned FONT_COUNT = 5,
  parameter int unsigned HOLD_DEPTH = 63
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  kgww_in_if.sink                              in_ch,
  kgww_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [kgww_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kgww_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // The controller only sees status flags and only drives commands; all
  // storage and arithmetic live in the datapath.
  kgww_pkg::kgww_cmd_t    cmd;
  kgww_pkg::kgww_status_t status;

  kgww_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  kgww_datapath #(
    .FONT_COUNT (FONT_COUNT),
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
